### rtl/core/ffha_pkg.sv
// Package for the first-fit heap allocator: item structs, opcodes, status codes,
// register indexes and sequencer states. No dependencies.
package ffha_pkg;

    localparam int CFG_IDX_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_START = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_END   = CFG_IDX_W'(1);

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_OOM    = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    localparam logic [31:0] HEAP_START_RST = 32'd0;
    localparam logic [31:0] HEAP_END_RST   = 32'd65536;

    typedef struct packed {
        logic        opcode;
        logic [31:0] request_bytes;
        logic [31:0] release_address;
    } t_req;

    typedef struct packed {
        logic [31:0] data_address;
        logic [1:0]  status;
    } t_rsp;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AREAD,
        S_AEVAL,
        S_SPLIT,
        S_FREAD,
        S_FEVAL,
        S_MREAD,
        S_MEVAL,
        S_WBACK,
        S_DONE
    } t_state;

endpackage

### rtl/core/first_fit_heap_allocator.sv
// First-fit heap allocator: block header store, walk sequencer and config registers.
// Depends on ffha_pkg.
//
// Allocate reads and evaluates each block header in turn until a free block fits, marks it
// used and splits off the rest if large enough, or reports out of memory past the span.
// Release walks to the target header, merges the free blocks after it and writes back its
// header; a release of zero does no walk, and one that matches no header is rejected.
// One item at a time: the next item is taken the cycle after the result is posted, later
// while the previous result is still held. Reset (sync, active low) and each write to the
// heap start or end register rebuild the heap while idle, writing only header entry 0.
module first_fit_heap_allocator #(
    parameter int HEAP_BYTES   = 65536,
    parameter int HEADER_BYTES = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  ffha_pkg::t_req                 i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output ffha_pkg::t_rsp                 o_out_item,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]                    i_cfg_data
);
    import ffha_pkg::*;

    localparam int DEPTH = HEAP_BYTES / 16;
    localparam int AW    = $clog2(DEPTH);
    localparam int OW    = $clog2(HEAP_BYTES + 1);
    localparam int SW    = $clog2(HEAP_BYTES);
    localparam int EW    = SW + 1;

    localparam logic [OW-1:0] HDR_O  = OW'(HEADER_BYTES);
    localparam logic [33:0]   HDR_34 = 34'(HEADER_BYTES);
    localparam logic [33:0]   CAP_34 = 34'(HEAP_BYTES);

    logic [EW-1:0] r_mem [DEPTH];
    logic [EW-1:0] r_rdata;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic [EW-1:0] w_wdata;
    logic [AW-1:0] w_raddr;

    t_state        r_state, n_state;
    logic          r_build, n_build;
    logic [31:0]   r_start, r_end;
    logic [31:0]   r_base, n_base;
    logic [OW-1:0] r_span, n_span;
    logic [OW-1:0] r_off, n_off;
    logic [OW-1:0] r_hold, n_hold;
    logic [SW-1:0] r_acc, n_acc;
    logic [SW-1:0] r_rest, n_rest;
    logic [32:0]   r_req, n_req;
    logic [33:0]   r_tgt, n_tgt;
    logic          r_out_valid, n_out_valid;
    t_rsp          r_out, n_out;
    t_rsp          r_res, n_res;

    logic [SW-1:0] w_sz;
    logic          w_free;
    logic [OW-1:0] w_step;
    logic [33:0]   w_base34;
    logic [33:0]   w_span34;
    logic [OW-1:0] w_split_off;
    logic          w_in_acc;

    assign w_sz        = r_rdata[EW-1:1];
    assign w_free      = r_rdata[0];
    assign w_step      = r_off + HDR_O + OW'(w_sz);
    assign w_base34    = ({2'b00, r_start} + 34'd15) & ~34'd15;
    assign w_span34    = {2'b00, r_end} - w_base34;
    assign w_split_off = r_off + HDR_O + OW'(r_req);
    assign w_in_acc    = i_in_valid && o_in_ready;

    assign o_in_ready  = (r_state == S_IDLE) && !r_build;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_build     <= 1'b1;
            r_start     <= HEAP_START_RST;
            r_end       <= HEAP_END_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_build     <= n_build;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_HEAP_START) begin
                    r_start <= i_cfg_data;
                end else if (i_cfg_index == REG_HEAP_END) begin
                    r_end <= i_cfg_data;
                end
            end
        end
        r_base <= n_base;
        r_span <= n_span;
        r_off  <= n_off;
        r_hold <= n_hold;
        r_acc  <= n_acc;
        r_rest <= n_rest;
        r_req  <= n_req;
        r_tgt  <= n_tgt;
        r_out  <= n_out;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_build     = r_build;
        n_base      = r_base;
        n_span      = r_span;
        n_off       = r_off;
        n_hold      = r_hold;
        n_acc       = r_acc;
        n_rest      = r_rest;
        n_req       = r_req;
        n_tgt       = r_tgt;
        n_out       = r_out;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        w_we        = 1'b0;
        w_waddr     = AW'(r_off >> 4);
        w_wdata     = '0;
        w_raddr     = AW'(r_off >> 4);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (r_build) begin
                    n_build = 1'b0;
                    n_base  = w_base34[31:0];
                    n_span  = '0;
                    if (w_base34 < {2'b00, r_end}) begin
                        if (w_span34 > CAP_34) begin
                            n_span = OW'(HEAP_BYTES);
                        end else if (w_span34 >= HDR_34) begin
                            n_span = OW'(w_span34);
                        end
                    end
                    if (n_span != '0) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = {SW'(n_span - HDR_O), 1'b1};
                    end
                end else if (w_in_acc) begin
                    n_off = '0;
                    n_res = '{data_address: 32'd0, status: ST_DONE};
                    if (i_in_item.opcode == OP_ALLOC) begin
                        n_req   = ({1'b0, i_in_item.request_bytes} + 33'd15) & ~33'd15;
                        n_state = S_AREAD;
                    end else if (i_in_item.release_address == 32'd0) begin
                        n_state = S_DONE;
                    end else begin
                        n_tgt   = {2'b00, i_in_item.release_address} - {2'b00, r_base}
                                  - HDR_34;
                        n_state = S_FREAD;
                    end
                end
            end
            S_AREAD: begin
                if (r_off >= r_span) begin
                    n_res.status = ST_OOM;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_AEVAL;
                end
            end
            S_AEVAL: begin
                if (w_free && ({{(33-SW){1'b0}}, w_sz} >= r_req)) begin
                    w_we    = 1'b1;
                    w_wdata = {w_sz, 1'b0};
                    n_res.data_address = r_base + 32'(r_off) + 32'(HEADER_BYTES);
                    n_state = S_DONE;
                    if ({{(34-SW){1'b0}}, w_sz} > {1'b0, r_req} + HDR_34 + 34'd16) begin
                        w_wdata = {SW'(r_req), 1'b0};
                        n_rest  = w_sz - SW'(r_req) - SW'(HEADER_BYTES);
                        n_state = S_SPLIT;
                    end
                end else begin
                    n_off   = w_step;
                    n_state = S_AREAD;
                end
            end
            S_SPLIT: begin
                w_we    = 1'b1;
                w_waddr = AW'(w_split_off >> 4);
                w_wdata = {r_rest, 1'b1};
                n_state = S_DONE;
            end
            S_FREAD: begin
                if (r_off >= r_span) begin
                    n_res.status = ST_REJECT;
                    n_state      = S_DONE;
                end else begin
                    n_state = S_FEVAL;
                end
            end
            S_FEVAL: begin
                n_off = w_step;
                if ({{(34-OW){1'b0}}, r_off} == r_tgt) begin
                    n_acc   = w_sz;
                    n_hold  = r_off;
                    n_state = S_MREAD;
                end else begin
                    n_state = S_FREAD;
                end
            end
            S_MREAD: begin
                n_state = (r_off >= r_span) ? S_WBACK : S_MEVAL;
            end
            S_MEVAL: begin
                if (w_free) begin
                    n_acc   = r_acc + w_sz + SW'(HEADER_BYTES);
                    n_off   = w_step;
                    n_state = S_MREAD;
                end else begin
                    n_state = S_WBACK;
                end
            end
            S_WBACK: begin
                w_we    = 1'b1;
                w_waddr = AW'(r_hold >> 4);
                w_wdata = {r_acc, 1'b1};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (i_cfg_valid && o_cfg_ready &&
            (i_cfg_index == REG_HEAP_START || i_cfg_index == REG_HEAP_END)) begin
            n_build = 1'b1;
        end
    end

    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !o_in_ready)
        else $error("input ready while a walk is in progress");

    a_walk_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_AREAD || r_state == S_FREAD || r_state == S_MREAD)
        |-> (r_off <= r_span))
        else $error("header walk ran past the heap span");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_res.status != ST_DONE) |-> (r_res.data_address == 32'd0))
        else $error("failed item carries a nonzero address");

    a_split_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SPLIT) |-> (w_split_off < r_span))
        else $error("split header placed outside the heap");

endmodule

### tb/sv/first_fit_heap_allocator_tb.sv
// Self-checking bench for first_fit_heap_allocator: directed and random alloc/free items,
// heap region reprogramming, random stalls, checked against an in-bench heap predictor.
// Depends on ffha_pkg and the first_fit_heap_allocator RTL.
module first_fit_heap_allocator_tb;
    import ffha_pkg::*;

    localparam bit [63:0] HEAP_SPAN_MAX = 64'd65536;
    localparam bit [63:0] HDR_BYTES     = 64'd16;
    localparam bit [63:0] GRAIN         = 64'd16;
    localparam int        BLOCK_MAX     = 4096;
    localparam int        QUEUE_DEPTH   = 4;
    localparam int        SETTLE        = 16;
    localparam int        HOLD_CYCLES   = 400;
    localparam int        CYCLE_LIMIT   = 50000000;
    localparam int        PRINT_MAX     = 50;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    t_req in_item = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    wire in_ready;
    wire out_valid;
    wire cfg_ready;
    t_rsp out_item;

    first_fit_heap_allocator uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // heap predictor state
    logic [31:0] heap_lo;
    logic [31:0] heap_hi;
    bit [63:0]   blk_base[$];
    bit [63:0]   blk_bytes[$];
    bit          blk_open[$];

    t_req        request_queue[$];
    t_rsp        awaited_replies[$];
    logic [31:0] live_addrs[$];
    logic [31:0] released_addrs[$];

    t_rsp oldest;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic pace_on = 1'b0;
    logic hold_go = 1'b0;
    logic hold_out = 1'b0;
    int   send_wait = 0;
    int   take_wait = 0;
    int   cycle_count = 0;
    int   mismatches = 0;
    int   items_sent = 0;
    int   reg_writes = 0;
    int   n_grant = 0;
    int   n_oom = 0;
    int   n_reject = 0;
    int   n_release = 0;

    function automatic void heap_rebuild();
        bit [63:0] base;
        bit [63:0] span;
        blk_base.delete();
        blk_bytes.delete();
        blk_open.delete();
        base = ({32'd0, heap_lo} + GRAIN - 64'd1) & ~(GRAIN - 64'd1);
        if (base < {32'd0, heap_hi}) begin
            span = {32'd0, heap_hi} - base;
            if (span > HEAP_SPAN_MAX)
                span = HEAP_SPAN_MAX;
            if (span >= HDR_BYTES) begin
                blk_base.push_back(base);
                blk_bytes.push_back(span - HDR_BYTES);
                blk_open.push_back(1'b1);
            end
        end
    endfunction

    function automatic void heap_write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        case (idx)
            REG_HEAP_START: begin
                heap_lo = val;
                heap_rebuild();
            end
            REG_HEAP_END: begin
                heap_hi = val;
                heap_rebuild();
            end
            default: ;
        endcase
    endfunction

    function automatic t_rsp heap_grant(logic [31:0] bytes);
        bit [63:0] need;
        bit [63:0] data;
        t_rsp r;
        r.data_address = '0;
        r.status = ST_OOM;
        need = ({32'd0, bytes} + GRAIN - 64'd1) & ~(GRAIN - 64'd1);
        for (int i = 0; i < blk_base.size(); i++) begin
            if (blk_open[i] && blk_bytes[i] >= need) begin
                if (blk_bytes[i] > need + HDR_BYTES + GRAIN && blk_base.size() < BLOCK_MAX) begin
                    blk_base.insert(i + 1, blk_base[i] + HDR_BYTES + need);
                    blk_bytes.insert(i + 1, blk_bytes[i] - need - HDR_BYTES);
                    blk_open.insert(i + 1, 1'b1);
                    blk_bytes[i] = need;
                end
                blk_open[i] = 1'b0;
                data = blk_base[i] + HDR_BYTES;
                r.data_address = data[31:0];
                r.status = ST_DONE;
                return r;
            end
        end
        return r;
    endfunction

    function automatic t_rsp heap_release(logic [31:0] where);
        int hit;
        t_rsp r;
        r.data_address = '0;
        r.status = ST_DONE;
        hit = -1;
        if (where != '0) begin
            for (int i = 0; i < blk_base.size() && hit < 0; i++)
                if (blk_base[i] + HDR_BYTES == {32'd0, where})
                    hit = i;
            if (hit < 0) begin
                r.status = ST_REJECT;
            end else begin
                blk_open[hit] = 1'b1;
                while (hit + 1 < blk_base.size() && blk_open[hit + 1]) begin
                    blk_bytes[hit] = blk_bytes[hit] + blk_bytes[hit + 1] + HDR_BYTES;
                    blk_base.delete(hit + 1);
                    blk_bytes.delete(hit + 1);
                    blk_open.delete(hit + 1);
                end
            end
        end
        return r;
    endfunction

    function automatic t_rsp heap_predict(t_req q);
        if (q.opcode == OP_ALLOC)
            return heap_grant(q.request_bytes);
        else
            return heap_release(q.release_address);
    endfunction

    task automatic report_mismatch(input string what);
        mismatches++;
        if (mismatches <= PRINT_MAX)
            $display("cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("first_fit_heap_allocator_tb NOT OK");
            $finish;
        end
    end

    // request driver
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || in_fire) begin
            if (send_wait > 0) begin
                send_wait = send_wait - 1;
                in_valid <= 1'b0;
            end else if (request_queue.size() != 0) begin
                in_item <= request_queue.pop_front();
                in_valid <= 1'b1;
                send_wait = pace_on ? $urandom_range(0, 5) : 0;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_fire)
                take_wait = pace_on ? $urandom_range(0, 5) : 0;
            if (hold_out || take_wait > 0) begin
                out_ready <= 1'b0;
                if (!hold_out)
                    take_wait = take_wait - 1;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    initial begin
        wait (hold_go);
        @(negedge clk);
        hold_out <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_out <= 1'b0;
    end

    // monitor and checker
    always @(posedge clk) begin
        in_fire <= rst_n && in_valid && in_ready;
        out_fire <= rst_n && out_valid && out_ready;
        if (rst_n && in_valid && in_ready)
            awaited_replies.push_back(heap_predict(in_item));
        if (rst_n && out_valid && out_ready) begin
            if (awaited_replies.size() == 0) begin
                report_mismatch("result item with no request outstanding");
            end else begin
                oldest = awaited_replies.pop_front();
                if (out_item.data_address !== oldest.data_address)
                    report_mismatch($sformatf("data_address %h, expected %h",
                        out_item.data_address, oldest.data_address));
                if (out_item.status !== oldest.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                        out_item.status, oldest.status));
                if (oldest.status == ST_OOM)
                    n_oom++;
                else if (oldest.status == ST_REJECT)
                    n_reject++;
                else if (oldest.data_address != '0) begin
                    n_grant++;
                    live_addrs.push_back(oldest.data_address);
                end else
                    n_release++;
            end
        end
    end

    function automatic t_req make_req(logic op, logic [31:0] bytes, logic [31:0] addr);
        t_req q;
        q.opcode = op;
        q.request_bytes = bytes;
        q.release_address = addr;
        return q;
    endfunction

    task automatic send_item(t_req q);
        do @(posedge clk); while (request_queue.size() >= QUEUE_DEPTH);
        request_queue.push_back(q);
        items_sent++;
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (request_queue.size() != 0 || in_valid || awaited_replies.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        wait_idle();
        repeat (SETTLE) @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        heap_write_reg(idx, val);
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_heap(logic [31:0] lo, logic [31:0] hi);
        write_reg(REG_HEAP_START, lo);
        write_reg(REG_HEAP_END, hi);
        live_addrs.delete();
        released_addrs.delete();
    endtask

    // mostly well-formed alloc/free traffic, with a little junk release noise
    task automatic send_random(int count, int live_goal);
        t_req q;
        int roll;
        int k;
        repeat (count) begin
            @(negedge clk);
            q.opcode = OP_ALLOC;
            q.request_bytes = $urandom;
            q.release_address = $urandom;
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                q.opcode = OP_FREE;
                case (roll % 4)
                    0: q.release_address = '0;
                    1: if (released_addrs.size() != 0)
                        q.release_address =
                            released_addrs[$urandom_range(0, released_addrs.size() - 1)];
                    2: if (live_addrs.size() != 0)
                        q.release_address =
                            live_addrs[$urandom_range(0, live_addrs.size() - 1)] + 32'd8;
                    default: ;
                endcase
            end else if (live_addrs.size() != 0 &&
                         roll < (live_addrs.size() >= live_goal ? 75 : 35)) begin
                k = $urandom_range(0, live_addrs.size() - 1);
                q.opcode = OP_FREE;
                q.release_address = live_addrs[k];
                live_addrs.delete(k);
                released_addrs.push_back(q.release_address);
                if (released_addrs.size() > 32)
                    void'(released_addrs.pop_front());
            end else begin
                case ($urandom_range(0, 19))
                    0: ;
                    1: q.request_bytes = $urandom_range(4096, 16384);
                    2, 3: q.request_bytes = $urandom_range(0, 16);
                    default: q.request_bytes = $urandom_range(0, 1024);
                endcase
            end
            send_item(q);
        end
    endtask

    initial begin
        logic [31:0] lo_list[9];
        logic [31:0] hi_list[9];
        heap_lo = HEAP_START_RST;
        heap_hi = HEAP_END_RST;
        heap_rebuild();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: zero-byte, huge, exact fit, split edge, zero/bogus/double release
        send_item(make_req(OP_ALLOC, 32'd0, 32'd0));
        send_item(make_req(OP_ALLOC, 32'd1, 32'd0));
        send_item(make_req(OP_ALLOC, 32'hFFFF_FFFF, 32'd0));
        send_item(make_req(OP_ALLOC, 32'hFFFF_FFF1, 32'd0));
        send_item(make_req(OP_ALLOC, 32'd65520, 32'd0));
        send_item(make_req(OP_FREE, 32'd0, 32'd0));
        send_item(make_req(OP_FREE, 32'd0, 32'd8));
        send_item(make_req(OP_FREE, 32'd0, 32'hFFFF_FFFF));
        send_item(make_req(OP_FREE, 32'd0, 32'd32));
        send_item(make_req(OP_FREE, 32'd0, 32'd32));
        send_item(make_req(OP_FREE, 32'd0, 32'd16));
        send_item(make_req(OP_ALLOC, 32'd65520, 32'd0));
        send_item(make_req(OP_ALLOC, 32'd0, 32'd0));
        send_item(make_req(OP_FREE, 32'd0, 32'd16));
        send_item(make_req(OP_ALLOC, 32'd65472, 32'd0));
        send_item(make_req(OP_ALLOC, 32'd17, 32'd0));
        send_item(make_req(OP_FREE, 32'd0, 32'd16));
        send_item(make_req(OP_FREE, 32'd0, 32'd65504));
        send_item(make_req(OP_ALLOC, 32'd65473, 32'd0));
        send_item(make_req(OP_FREE, 32'hFFFF_FFFF, 32'd16));
        send_item(make_req(OP_ALLOC, 32'd16, 32'hFFFF_FFFF));
        send_item(make_req(OP_FREE, 32'hFFFF_FFFF, 32'd16));
        wait_idle();

        pace_on = 1'b1;
        send_random(300, 16);
        hold_go = 1'b1;
        for (int chunk = 0; chunk < 7; chunk++) begin
            pace_on = (chunk % 3) != 2;
            send_random(150, $urandom_range(4, 48));
        end
        pace_on = 1'b1;

        lo_list = '{32'h0001_0003, 32'hFFFF_FFF8, 32'h0, 32'h100, 32'h100,
                    32'hFFFF_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0};
        hi_list = '{32'h0001_3003, 32'hFFFF_FFFF, 32'h0, 32'h10F, 32'h110,
                    32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0};
        lo_list[8] = $urandom;
        hi_list[8] = lo_list[8] + $urandom_range(16, 70000);
        for (int s = 0; s < 9; s++) begin
            set_heap(lo_list[s], hi_list[s]);
            send_random(60, 48);
        end

        // unlisted register indexes leave the heap alone
        write_reg(REG_UNUSED_LO, $urandom);
        write_reg(REG_UNUSED_HI, $urandom);
        send_random(30, 24);

        set_heap(HEAP_START_RST, HEAP_END_RST);
        send_random(100, 32);

        wait_idle();
        repeat (SETTLE) @(posedge clk);
        $display("Sent %0d requests across %0d register writes and several heap regions.",
                 items_sent, reg_writes);
        $display("Results: %0d grants, %0d releases, %0d out of memory, %0d rejected.",
                 n_grant, n_release, n_oom, n_reject);
        if (mismatches == 0)
            $display("first_fit_heap_allocator_tb OK");
        else
            $display("first_fit_heap_allocator_tb NOT OK");
        $finish;
    end
endmodule

### filelist.f
rtl/core/ffha_pkg.sv
rtl/core/first_fit_heap_allocator.sv
tb/sv/first_fit_heap_allocator_tb.sv
